>>> hw/rtl/timelapse_shot_sequencer_assert.svh
// Assertion macros for the timelapse shot sequencer.
// Included by modules that check their own logic; no other dependencies.
`ifndef TIMELAPSE_SHOT_SEQUENCER_ASSERT_SVH
`define TIMELAPSE_SHOT_SEQUENCER_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define TSS_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sequencer check failed");
// Next-cycle implication, disabled during reset.
`define TSS_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sequencer check failed");
`else
`define TSS_ASSERT_IMP(name, clk, rst, ante, cons)
`define TSS_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

>>> hw/rtl/tss_pkg.sv
// Shared types and constants for the timelapse shot sequencer.
// No dependencies.
package tss_pkg;

  localparam int unsigned IntervalW = 22;
  localparam int unsigned ShotsW    = 14;
  localparam int unsigned ExpW      = 10;
  localparam int unsigned SettleW   = 7;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 22;

  typedef logic [IntervalW-1:0] ms_t;
  typedef logic [ShotsW-1:0]    shots_t;
  typedef logic [1:0]           opcode_t;
  typedef logic [2:0]           status_t;
  typedef logic [1:0]           mode_t;
  typedef logic [CfgIdxW-1:0]   cfg_idx_t;
  typedef logic [CfgDataW-1:0]  cfg_data_t;

  localparam opcode_t OP_TICK   = 2'd0;
  localparam opcode_t OP_TOGGLE = 2'd1;
  localparam opcode_t OP_STOP   = 2'd2;

  localparam mode_t MODE_IDLE   = 2'd0;
  localparam mode_t MODE_REST   = 2'd1;
  localparam mode_t MODE_EXPOSE = 2'd2;
  localparam mode_t MODE_PAUSE  = 2'd3;

  localparam status_t ST_IDLE   = 3'd0;
  localparam status_t ST_REST   = 3'd1;
  localparam status_t ST_EXPOSE = 3'd2;
  localparam status_t ST_PAUSE  = 3'd3;
  localparam status_t ST_DONE   = 3'd4;

  localparam cfg_idx_t REG_INTERVAL = 3'd0;
  localparam cfg_idx_t REG_TOTAL    = 3'd1;
  localparam cfg_idx_t REG_BULB     = 3'd2;
  localparam cfg_idx_t REG_EXPOSURE = 3'd3;
  localparam cfg_idx_t REG_SETTLE   = 3'd4;
  localparam cfg_idx_t REG_MAIN     = 3'd5;
  localparam cfg_idx_t REG_REMOTE   = 3'd6;
  localparam cfg_idx_t REG_WIRELESS = 3'd7;

  localparam ms_t              INTERVAL_MIN = 22'd100;
  localparam ms_t              INTERVAL_MAX = 22'd3600000;
  localparam ms_t              INTERVAL_RST = 22'd5000;
  localparam shots_t           SHOT_MAX     = 14'd10000;
  localparam logic [ExpW-1:0]  EXP_MIN      = 10'd1;
  localparam logic [ExpW-1:0]  EXP_MAX      = 10'd900;
  localparam logic [ExpW-1:0]  EXP_RST      = 10'd15;
  localparam logic [SettleW-1:0] SETTLE_MAX = 7'd120;
  localparam ms_t              MS_PER_SEC   = 22'd1000;

endpackage

>>> hw/rtl/timelapse_shot_sequencer.sv
// Timelapse shot sequencer: intervalometer with quick and bulb shots.
// Depends on tss_pkg and timelapse_shot_sequencer_assert.svh.
//
//  channel  handshake             payload
//  in       in_valid / in_stall   opcode, lock_granted, wireless_press_ok
//  out      out_valid / out_stall hold_*, pulse_*, wireless_*, lock_held, status,
//                                 shots_taken, time_left_ms
//  cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One beat in, one beat out; each item passes through the single update step
// from the state registers into the result register.
// A new beat is taken every cycle while the result register is empty or drained.
// Result is held in its register while out_stall is high; input stalls only then.
// rst (synchronous) returns the mode to idle and the state and configuration registers to their defaults.
// cfg_ready is always high; writes are never stalled.
`include "timelapse_shot_sequencer_assert.svh"
module timelapse_shot_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  tss_pkg::opcode_t  opcode,
  input  logic              lock_granted,
  input  logic              wireless_press_ok,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              hold_main,
  output logic              hold_remote,
  output logic              pulse_main,
  output logic              pulse_remote,
  output logic              wireless_shot,
  output logic              wireless_press,
  output logic              wireless_release,
  output logic              lock_held,
  output tss_pkg::status_t  status,
  output tss_pkg::shots_t   shots_taken,
  output tss_pkg::ms_t      time_left_ms,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  tss_pkg::cfg_idx_t cfg_index,
  input  tss_pkg::cfg_data_t cfg_data
);
  import tss_pkg::*;

  // configuration
  ms_t                interval_ms;
  shots_t             total_shots;
  logic               bulb_mode;
  logic [ExpW-1:0]    exposure_sec;
  logic [SettleW-1:0] settle_sec;
  logic               main_line_on;
  logic               remote_line_on;
  logic               wireless_on;

  // sequencer state
  mode_t  run_mode, run_mode_next;
  ms_t    elapsed_ms, elapsed_ms_next;
  shots_t shot_count, shot_count_next;
  logic   held_main, held_main_next;
  logic   held_remote, held_remote_next;

  logic in_take;
  logic cfg_take;

  ms_t wait_tgt, exp_tgt, run_tgt, out_tgt, elapsed_sat;
  logic fire_main, fire_remote;
  logic p_main, p_remote, w_shot, w_press, w_rel;
  status_t st;
  ms_t left;
  shots_t shot_inc;

  ms_t                v_int;
  shots_t             v_tot;
  logic [ExpW-1:0]    v_exp;
  logic [SettleW-1:0] v_set;

  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid && cfg_ready;
  assign in_stall  = out_valid && out_stall;
  assign in_take   = in_valid && !in_stall;

  assign v_int = cfg_data[IntervalW-1:0];
  assign v_tot = cfg_data[ShotsW-1:0];
  assign v_exp = cfg_data[ExpW-1:0];
  assign v_set = cfg_data[SettleW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_ms    <= INTERVAL_RST;
      total_shots    <= '0;
      bulb_mode      <= 1'b0;
      exposure_sec   <= EXP_RST;
      settle_sec     <= '0;
      main_line_on   <= 1'b1;
      remote_line_on <= 1'b0;
      wireless_on    <= 1'b0;
    end else if (cfg_take) begin
      unique case (cfg_index)
        REG_INTERVAL: begin
          if (v_int < INTERVAL_MIN) interval_ms <= INTERVAL_MIN;
          else if (v_int > INTERVAL_MAX) interval_ms <= INTERVAL_MAX;
          else interval_ms <= v_int;
        end
        REG_TOTAL:    total_shots <= (v_tot > SHOT_MAX) ? SHOT_MAX : v_tot;
        REG_BULB:     bulb_mode <= cfg_data[0];
        REG_EXPOSURE: begin
          if (v_exp < EXP_MIN) exposure_sec <= EXP_MIN;
          else if (v_exp > EXP_MAX) exposure_sec <= EXP_MAX;
          else exposure_sec <= v_exp;
        end
        REG_SETTLE:   settle_sec <= (v_set > SETTLE_MAX) ? SETTLE_MAX : v_set;
        REG_MAIN:     main_line_on <= cfg_data[0];
        REG_REMOTE:   remote_line_on <= cfg_data[0];
        REG_WIRELESS: wireless_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // targets: constant multiplies by 1000, max 3720000 fits in 22 bits
  always_comb begin
    wait_tgt = interval_ms;
    if (bulb_mode) wait_tgt = interval_ms + ms_t'(settle_sec) * MS_PER_SEC;
    exp_tgt = ms_t'(exposure_sec) * MS_PER_SEC;
  end

  // with no channel enabled the main line fires
  assign fire_main   = main_line_on || (!remote_line_on && !wireless_on);
  assign fire_remote = remote_line_on;

  assign run_tgt     = (run_mode == MODE_EXPOSE) ? exp_tgt : wait_tgt;
  assign elapsed_sat = (elapsed_ms >= run_tgt) ? run_tgt : elapsed_ms + ms_t'(1);
  assign shot_inc    = (shot_count < SHOT_MAX) ? shot_count + shots_t'(1) : shot_count;

  always_comb begin
    run_mode_next    = run_mode;
    elapsed_ms_next  = elapsed_ms;
    shot_count_next  = shot_count;
    held_main_next   = held_main;
    held_remote_next = held_remote;
    p_main   = 1'b0;
    p_remote = 1'b0;
    w_shot   = 1'b0;
    w_press  = 1'b0;
    w_rel    = 1'b0;
    unique case (opcode)
      OP_TOGGLE: begin
        if (run_mode == MODE_REST || run_mode == MODE_EXPOSE) begin
          if (run_mode == MODE_EXPOSE) begin
            held_main_next   = 1'b0;
            held_remote_next = 1'b0;
            w_rel            = wireless_on;
          end
          run_mode_next = MODE_PAUSE;
        end else if (run_mode == MODE_PAUSE) begin
          run_mode_next   = MODE_REST;
          elapsed_ms_next = '0;
        end else begin
          run_mode_next   = MODE_REST;
          elapsed_ms_next = '0;
          shot_count_next = '0;
        end
      end
      OP_STOP: begin
        if (run_mode == MODE_EXPOSE) begin
          held_main_next   = 1'b0;
          held_remote_next = 1'b0;
          w_rel            = wireless_on;
        end
        run_mode_next = MODE_IDLE;
      end
      OP_TICK: begin
        if (run_mode == MODE_EXPOSE) begin
          elapsed_ms_next = elapsed_sat;
          if (elapsed_sat >= run_tgt) begin
            held_main_next   = 1'b0;
            held_remote_next = 1'b0;
            w_rel            = wireless_on;
            shot_count_next  = shot_inc;
            run_mode_next    = MODE_REST;
            elapsed_ms_next  = '0;
          end
        end else if (run_mode == MODE_REST) begin
          elapsed_ms_next = elapsed_sat;
          if (elapsed_sat >= run_tgt) begin
            if (total_shots != '0 && shot_count >= total_shots) begin
              run_mode_next = MODE_IDLE;
            end else if (bulb_mode) begin
              // refused start stays saturated and retries next tick
              if (lock_granted) begin
                w_press = wireless_on;
                if (!(wireless_on && !fire_main && !fire_remote && !wireless_press_ok)) begin
                  held_main_next   = fire_main;
                  held_remote_next = fire_remote;
                  run_mode_next    = MODE_EXPOSE;
                  elapsed_ms_next  = '0;
                end
              end
            end else begin
              // quick shot counts even with the lock refused
              p_main          = lock_granted && fire_main;
              p_remote        = lock_granted && fire_remote;
              w_shot          = lock_granted && wireless_on;
              shot_count_next = shot_inc;
              elapsed_ms_next = '0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign out_tgt = (run_mode_next == MODE_EXPOSE) ? exp_tgt : wait_tgt;

  always_comb begin
    left = '0;
    unique case (run_mode_next)
      MODE_REST: begin
        st = ST_REST;
        if (elapsed_ms_next < out_tgt) left = out_tgt - elapsed_ms_next;
      end
      MODE_EXPOSE: begin
        st = ST_EXPOSE;
        if (elapsed_ms_next < out_tgt) left = out_tgt - elapsed_ms_next;
      end
      MODE_PAUSE: st = ST_PAUSE;
      default: begin
        st = (total_shots != '0 && shot_count_next >= total_shots) ? ST_DONE : ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode    <= MODE_IDLE;
      elapsed_ms  <= '0;
      shot_count  <= '0;
      held_main   <= 1'b0;
      held_remote <= 1'b0;
    end else if (in_take) begin
      run_mode    <= run_mode_next;
      elapsed_ms  <= elapsed_ms_next;
      shot_count  <= shot_count_next;
      held_main   <= held_main_next;
      held_remote <= held_remote_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      hold_main        <= (run_mode_next == MODE_EXPOSE) && held_main_next;
      hold_remote      <= (run_mode_next == MODE_EXPOSE) && held_remote_next;
      pulse_main       <= p_main;
      pulse_remote     <= p_remote;
      wireless_shot    <= w_shot;
      wireless_press   <= w_press;
      wireless_release <= w_rel;
      lock_held        <= (run_mode_next == MODE_EXPOSE);
      status           <= st;
      shots_taken      <= shot_count_next;
      time_left_ms     <= left;
    end
  end

  `TSS_ASSERT_IMP(a_held_only_exposing, clk, rst, held_main || held_remote, run_mode == MODE_EXPOSE)
  `TSS_ASSERT_IMP(a_lock_means_exposing, clk, rst, out_valid && lock_held, status == ST_EXPOSE)
  `TSS_ASSERT_IMP(a_pulse_while_resting, clk, rst, out_valid && (pulse_main || pulse_remote), status == ST_REST)
  `TSS_ASSERT_NXT(a_take_gives_result, clk, rst, in_take, out_valid)
  `TSS_ASSERT_IMP(a_press_not_with_pulse, clk, rst, out_valid && wireless_press, !wireless_shot && !pulse_main)

endmodule
